FILE: design/epipolar_distance_squared_defines.svh
// Assertion macros shared by the epipolar distance design.
// Depends on nothing; taken in by the top level with an include.
`ifndef EPIPOLAR_DISTANCE_SQUARED_DEFINES_SVH
`define EPIPOLAR_DISTANCE_SQUARED_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("epd assertion failed");

// Next-cycle implication, checked outside reset.
`define EPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("epd assertion failed");

`endif

FILE: design/epd_pkg.sv
// Package of the epipolar distance block: widths and register indexes.
// Depends on nothing; used by the interfaces and the top level.
package epd_pkg;

   localparam int COORD_WIDTH        = 16;
   localparam int DIST_WIDTH         = 32;
   localparam int CSR_DATA_WIDTH     = 63;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int COEF_WIDTH_DEFAULT = 21;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_F_ROW0 = 2'd0,
      CSR_F_ROW1 = 2'd1,
      CSR_F_ROW2 = 2'd2
   } csr_index_type;

endpackage

FILE: design/epd_ifc.sv
// Request and response channel interfaces of the epipolar distance block.
// Depends on epd_pkg for the field widths.
interface epd_req_if;
   import epd_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  first_x;
   logic signed [COORD_WIDTH-1:0]  first_y;
   logic signed [COORD_WIDTH-1:0]  second_x;
   logic signed [COORD_WIDTH-1:0]  second_y;
   modport source (output valid, first_x, first_y, second_x, second_y, input ready);
   modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface epd_rsp_if;
   import epd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [DIST_WIDTH-1:0]  dist_sq;
   logic                   saturated;
   logic                   degenerate;
   modport source (output valid, dist_sq, saturated, degenerate, input ready);
   modport sink   (input valid, dist_sq, saturated, degenerate, output ready);
endinterface

FILE: design/epipolar_distance_squared.sv
// Squared point-to-epipolar-line distance with a pipelined divider.
// Depends on epd_pkg, the channel interfaces and the assertion macro header.
//
// Usage:
//   The fundamental matrix is loaded row by row through the csr_ port
//   (csr_we, csr_index, csr_wdata), three coefficients per row, column 0
//   in the low bits. Write it only while no request is in flight.
//   Each request on req_chan carries a point pair; each response on
//   rsp_chan carries dist_sq (Q24.8), saturated and degenerate.
// Stages: a request passes through eight arithmetic stages (products, line,
//   dot product, squares, divider entry checks) and 32 restoring divider
//   stages, one quotient bit per stage, before its response is valid.
// Throughput: one request per cycle. The whole pipeline moves together;
//   when the response is held by the receiver it freezes, and req_chan.ready
//   drops, so nothing is lost or repeated. Empty slots do not block.
// Reset: synchronous, clears all stage valid bits and the matrix rows.
`include "epipolar_distance_squared_defines.svh"

module epipolar_distance_squared #(
   parameter int COEF_WIDTH = epd_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [epd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [epd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   epd_req_if.sink                            req_chan,
   epd_rsp_if.source                          rsp_chan
);
   import epd_pkg::*;

   localparam int CW  = COEF_WIDTH;
   localparam int PW  = CW + 16;           // coefficient times coordinate
   localparam int LW  = CW + 17;           // line term, signed
   localparam int LAW = CW + 16;           // line term magnitude
   localparam int DW  = CW + 33;           // dot product, signed
   localparam int DAW = CW + 32;           // dot product magnitude
   localparam int LB  = (LAW + 1) / 2;     // low split of line magnitude
   localparam int LHB = LAW - LB;
   localparam int DB  = (DAW + 1) / 2;     // low split of dot magnitude
   localparam int DHB = DAW - DB;
   localparam int SW  = 2 * LAW + 1;       // sum of squared normal terms
   localparam int RW  = 2 * DAW;           // squared dot product
   localparam int QW  = DIST_WIDTH;
   localparam int NST = 8 + QW;            // total stages

   logic advance;
   logic [NST:1] vld_ff;

   logic [CSR_DATA_WIDTH-1:0] row_ff [3];

   // Configuration writes; indexes beyond the last row are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_F_ROW0: row_ff[0] <= csr_wdata;
            CSR_F_ROW1: row_ff[1] <= csr_wdata;
            CSR_F_ROW2: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output slot is empty or taken.
   assign advance        = !vld_ff[NST] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-1:1], req_chan.valid};
      end
   end

   // Stage 1: coefficient times first-image coordinate.
   logic signed [PW-1:0]        p0_ff [3];
   logic signed [PW-1:0]        p1_ff [3];
   logic signed [CW-1:0]        c2_ff [3];
   logic signed [COORD_WIDTH-1:0] x2_1_ff, y2_1_ff;

   for (genvar r = 0; r < 3; r++) begin : g_rows
      logic signed [CW-1:0] c0, c1;
      assign c0 = $signed(row_ff[r][0 +: CW]);
      assign c1 = $signed(row_ff[r][CW +: CW]);
      always_ff @(posedge clock) begin
         if (advance) begin
            p0_ff[r] <= PW'(c0) * PW'(req_chan.first_x);
            p1_ff[r] <= PW'(c1) * PW'(req_chan.first_y);
            c2_ff[r] <= $signed(row_ff[r][2*CW +: CW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_1_ff <= req_chan.second_x;
         y2_1_ff <= req_chan.second_y;
      end
   end

   // Stage 2: epipolar line terms.
   logic signed [LW-1:0]          l_ff [3];
   logic signed [COORD_WIDTH-1:0] x2_2_ff, y2_2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            l_ff[r] <= LW'(p0_ff[r]) + LW'(p1_ff[r]) + (LW'(c2_ff[r]) <<< 4);
         end
         x2_2_ff <= x2_1_ff;
         y2_2_ff <= y2_1_ff;
      end
   end

   // Stage 3: line times second-image coordinate, normal magnitudes.
   logic signed [DW-1:0] m0_ff, m1_ff;
   logic signed [LW-1:0] l2_3_ff;
   logic [LAW-1:0]       al_ff [2];

   always_ff @(posedge clock) begin
      if (advance) begin
         m0_ff   <= DW'(l_ff[0]) * DW'(x2_2_ff);
         m1_ff   <= DW'(l_ff[1]) * DW'(y2_2_ff);
         l2_3_ff <= l_ff[2];
         for (int j = 0; j < 2; j++) begin
            al_ff[j] <= LAW'(l_ff[j] < 0 ? -l_ff[j] : l_ff[j]);
         end
      end
   end

   // Stage 4: dot product, partial squares of the normal terms.
   logic signed [DW-1:0] d_ff;
   logic [2*LB-1:0]      sll_ff [2];
   logic [LB+LHB-1:0]    shl_ff [2];
   logic [2*LHB-1:0]     shh_ff [2];

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff <= m0_ff + m1_ff + (DW'(l2_3_ff) <<< 4);
         for (int j = 0; j < 2; j++) begin
            sll_ff[j] <= (2*LB)'(al_ff[j][LB-1:0]) * (2*LB)'(al_ff[j][LB-1:0]);
            shl_ff[j] <= (LB+LHB)'(al_ff[j][LAW-1:LB]) * (LB+LHB)'(al_ff[j][LB-1:0]);
            shh_ff[j] <= (2*LHB)'(al_ff[j][LAW-1:LB]) * (2*LHB)'(al_ff[j][LAW-1:LB]);
         end
      end
   end

   // Stage 5: dot magnitude, normal length squared.
   logic [DAW-1:0] ad_ff;
   logic [SW-1:0]  s5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ad_ff <= DAW'(d_ff < 0 ? -d_ff : d_ff);
         s5_ff <= SW'(sll_ff[0]) + (SW'(shl_ff[0]) << (LB + 1)) + (SW'(shh_ff[0]) << (2*LB))
                + SW'(sll_ff[1]) + (SW'(shl_ff[1]) << (LB + 1)) + (SW'(shh_ff[1]) << (2*LB));
      end
   end

   // Stage 6: partial squares of the dot product.
   logic [2*DB-1:0]   dll_ff;
   logic [DB+DHB-1:0] dhl_ff;
   logic [2*DHB-1:0]  dhh_ff;
   logic [SW-1:0]     s6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dll_ff <= (2*DB)'(ad_ff[DB-1:0]) * (2*DB)'(ad_ff[DB-1:0]);
         dhl_ff <= (DB+DHB)'(ad_ff[DAW-1:DB]) * (DB+DHB)'(ad_ff[DB-1:0]);
         dhh_ff <= (2*DHB)'(ad_ff[DAW-1:DB]) * (2*DHB)'(ad_ff[DAW-1:DB]);
         s6_ff  <= s5_ff;
      end
   end

   // Stage 7: squared dot product.
   logic [RW-1:0] r7_ff;
   logic [SW-1:0] s7_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         r7_ff <= RW'(dll_ff) + (RW'(dhl_ff) << (DB + 1)) + (RW'(dhh_ff) << (2*DB));
         s7_ff <= s6_ff;
      end
   end

   // Stage 8 (divider entry): degenerate and overflow checks.
   logic [RW-1:0] rem_ff [QW+1];
   logic [SW-1:0] sd_ff  [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          sat_ff [QW+1];
   logic          deg_ff [QW+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= r7_ff;
         sd_ff[0]  <= s7_ff;
         q_ff[0]   <= '0;
         deg_ff[0] <= (s7_ff == '0);
         sat_ff[0] <= ({1'b0, r7_ff} >= (RW+1)'({s7_ff, QW'(0)}));
      end
   end

   // Divider stages: one quotient bit each, most significant first.
   for (genvar i = 1; i <= QW; i++) begin : g_div
      localparam int K = QW - i;
      logic [RW-1:0] trial;
      logic          take;
      assign trial = RW'(sd_ff[i-1]) << K;
      assign take  = rem_ff[i-1] >= trial;
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= take ? rem_ff[i-1] - trial : rem_ff[i-1];
            q_ff[i]   <= q_ff[i-1] | (QW'(take) << K);
            sd_ff[i]  <= sd_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
            deg_ff[i] <= deg_ff[i-1];
         end
      end
   end

   // Response fields from the last divider stage.
   assign rsp_chan.valid      = vld_ff[NST];
   assign rsp_chan.degenerate = deg_ff[QW];
   assign rsp_chan.saturated  = !deg_ff[QW] && sat_ff[QW];
   assign rsp_chan.dist_sq    = deg_ff[QW] ? '0 : (sat_ff[QW] ? '1 : q_ff[QW]);

   // Checks on the pipeline and on the result encoding.
   `EPD_ASSERT_NEXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[1])
   `EPD_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(vld_ff) && $stable(q_ff[QW]))
   `EPD_ASSERT_NOW(a_degenerate_zero, clock, reset, rsp_chan.valid && rsp_chan.degenerate, rsp_chan.dist_sq == '0 && !rsp_chan.saturated)
   `EPD_ASSERT_NOW(a_saturate_max, clock, reset, rsp_chan.valid && rsp_chan.saturated, rsp_chan.dist_sq == '1)

endmodule
